/* sv/apef_pkg.sv */
package apef_pkg;

    // Fixed geometry of a frame and of the held values
    localparam int MAX_CHANNELS        = 8;
    localparam int CNT_W               = 4;
    localparam int SAMPLE_W            = 16;
    localparam int MAG_W               = 15;
    localparam int COEF_W              = 15;
    localparam int PROD_W              = MAG_W + 1 + COEF_W;
    localparam int COEF_FRAC_BITS_DEF  = 14;
    localparam logic [MAG_W-1:0] FULL_MAG = 15'h7FFF;

    // Channel sum and reciprocal divide of the merge stage
    localparam int SUM_W    = SAMPLE_W + $clog2(MAX_CHANNELS);
    localparam int RECIP_W  = 23;
    localparam int DIV_SHIFT = 22;
    localparam int QPROD_W  = SUM_W + RECIP_W;

    // Register map, index = paddr[3:2]
    localparam logic [1:0] REG_CHANNEL_COUNT  = 2'd0;
    localparam logic [1:0] REG_DECAY_COEF     = 2'd1;
    localparam logic [1:0] REG_OUTPUT_COEF    = 2'd2;
    localparam logic [1:0] REG_THUMBNAIL_MODE = 2'd3;

    localparam logic [CNT_W-1:0]  RST_CHANNEL_COUNT = 4'd2;
    localparam logic [COEF_W-1:0] RST_DECAY_COEF    = 15'd13060;
    localparam logic [COEF_W-1:0] RST_OUTPUT_COEF   = 15'd13060;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PEAK,
        ST_EMUL,
        ST_EWB,
        ST_SMUL,
        ST_SWB
    } t_state;

    typedef struct packed {
        logic peak_upd;
        logic mul;
        logic wb;
        logic sm_step;
        logic clr;
    } t_lane_ctl;

    typedef struct packed {
        logic load;
        logic mul;
    } t_merge_ctl;

    // Magnitude of a sample, full-scale negative saturates
    function automatic logic [MAG_W-1:0] mag15(input logic signed [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] m;
        m = s[SAMPLE_W-1] ? SAMPLE_W'(-s) : SAMPLE_W'(s);
        return m[SAMPLE_W-1] ? FULL_MAG : m[MAG_W-1:0];
    endfunction

    // ceil(2^DIV_SHIFT / cnt) for cnt 1..8
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        case (cnt)
            4'd2:    r = 23'd2097152;
            4'd3:    r = 23'd1398102;
            4'd4:    r = 23'd1048576;
            4'd5:    r = 23'd838861;
            4'd6:    r = 23'd699051;
            4'd7:    r = 23'd599187;
            4'd8:    r = 23'd524288;
            default: r = 23'd4194304;
        endcase
        return r;
    endfunction

endpackage

/* sv/apef_lane.sv */
module apef_lane #(
    parameter int COEF_FRAC_BITS = apef_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  apef_pkg::t_lane_ctl          i_ctl,
    input  logic [apef_pkg::MAG_W-1:0]   i_mag,
    input  logic [apef_pkg::COEF_W-1:0]  i_env_coef,
    input  logic [apef_pkg::COEF_W-1:0]  i_sm_coef,
    output logic [apef_pkg::MAG_W-1:0]   o_result
);

    localparam int MW = apef_pkg::MAG_W;
    localparam int CW = apef_pkg::COEF_W;
    localparam int PW = apef_pkg::PROD_W;

    logic [MW-1:0]        r_peak, n_peak;
    logic [MW-1:0]        r_env, n_env;
    logic [MW-1:0]        r_sm, n_sm;
    logic signed [PW-1:0] r_prod, n_prod;

    logic [MW-1:0]           w_prev;
    logic [MW-1:0]           w_target;
    logic [CW-1:0]           w_coef;
    logic signed [MW:0]      w_diff;
    logic signed [MW+CW+1:0] w_prod_full;
    logic signed [PW-1:0]    w_q;
    logic signed [PW:0]      w_total;
    logic [MW-1:0]           w_result;

    // Select the pole being stepped: envelope follows peak, smoothed follows envelope
    always_comb begin
        w_prev   = i_ctl.sm_step ? r_sm : r_env;
        w_target = i_ctl.sm_step ? r_env : r_peak;
        w_coef   = i_ctl.sm_step ? i_sm_coef : i_env_coef;
    end

    // Multiply the error by the coefficient
    always_comb begin
        w_diff      = $signed({1'b0, w_prev}) - $signed({1'b0, w_target});
        w_prod_full = w_diff * $signed({1'b0, w_coef});
        n_prod      = $signed(w_prod_full[PW-1:0]);
    end

    // Floor shift, add target, clamp to 0..full scale
    always_comb begin
        w_q     = r_prod >>> COEF_FRAC_BITS;
        w_total = $signed({{(PW+1-MW){1'b0}}, w_target}) + $signed({w_q[PW-1], w_q});
        if (w_total[PW]) begin
            w_result = '0;
        end else if (w_total[PW-1:MW] != '0) begin
            w_result = apef_pkg::FULL_MAG;
        end else begin
            w_result = w_total[MW-1:0];
        end
    end

    // Update held state
    always_comb begin
        n_peak = r_peak;
        n_env  = r_env;
        n_sm   = r_sm;
        if (i_ctl.peak_upd && (i_mag > r_peak)) begin
            n_peak = i_mag;
        end
        if (i_ctl.clr) begin
            n_peak = '0;
        end
        if (i_ctl.wb && !i_ctl.sm_step) begin
            n_env = w_result;
        end
        if (i_ctl.wb && i_ctl.sm_step) begin
            n_sm = w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
            r_env  <= '0;
            r_sm   <= '0;
        end else begin
            r_peak <= n_peak;
            r_env  <= n_env;
            r_sm   <= n_sm;
        end
    end

    // Product register, payload only
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= n_prod;
        end
    end

    assign o_result = w_result;

endmodule

/* sv/apef_merge.sv */
module apef_merge (
    input  logic                                 i_clk,
    input  apef_pkg::t_merge_ctl                 i_ctl,
    input  logic signed [apef_pkg::SAMPLE_W-1:0] i_sample [apef_pkg::MAX_CHANNELS],
    input  logic [apef_pkg::MAX_CHANNELS-1:0]    i_active,
    input  logic [apef_pkg::CNT_W-1:0]           i_cnt,
    output logic [apef_pkg::MAG_W-1:0]           o_mean_mag
);

    localparam int SW = apef_pkg::SUM_W;
    localparam int QW = apef_pkg::QPROD_W;
    localparam int DS = apef_pkg::DIV_SHIFT;

    logic [SW-1:0]        r_abs_sum, n_abs_sum;
    logic [QW-1:0]        r_qprod, n_qprod;
    logic signed [SW-1:0] w_sum;
    logic [QW-DS-1:0]     w_quot;

    // Sum the active channels and take the magnitude
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < apef_pkg::MAX_CHANNELS; i++) begin
            if (i_active[i]) begin
                w_sum = w_sum + $signed({{(SW-apef_pkg::SAMPLE_W){i_sample[i][apef_pkg::SAMPLE_W-1]}},
                                         i_sample[i]});
            end
        end
        n_abs_sum = w_sum[SW-1] ? SW'(-w_sum) : SW'(w_sum);
    end

    // Divide by the channel count through its reciprocal
    always_comb begin
        n_qprod = QW'(r_abs_sum) * QW'(apef_pkg::recip(i_cnt));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_abs_sum <= n_abs_sum;
        end
        if (i_ctl.mul) begin
            r_qprod <= n_qprod;
        end
    end

    // Saturate the mean magnitude
    always_comb begin
        w_quot = r_qprod[QW-1:DS];
        if (w_quot[QW-DS-1:apef_pkg::MAG_W] != '0) begin
            o_mean_mag = apef_pkg::FULL_MAG;
        end else begin
            o_mean_mag = w_quot[apef_pkg::MAG_W-1:0];
        end
    end

endmodule

/* sv/audio_peak_envelope_follower_top.sv */
// Peak envelope follower for frames of up to eight 16-bit PCM channels.
// Input channel: i_in_valid / o_in_stall carry one frame per transaction,
// samples i_sample_0..7 and i_last_of_block. Output channel: o_out_valid /
// i_out_stall carry one result per block, o_env_out_0..7 and o_mix_env_out.
// Eight channel lanes and one mix lane each hold a block peak, an envelope and
// a smoothed value and share one multiplier per lane. A frame steps through
// accept, reciprocal divide of the channel sum, peak, envelope multiply and
// envelope write; a frame that ends a block adds the output smoothing
// multiply and write, and its result is valid in the cycle after that write.
// A new frame is taken only once the previous frame is through its steps.
// The result sits in an output register; when the receiver stalls, the next
// frame is still taken and processed, and only the next block-end frame
// waits in its smoothing multiply until the pending result is taken.
// Reset (synchronous, active low) clears all lanes and restores the register
// defaults. Registers sit on an APB port at byte addresses 0, 4, 8 and 12; the user
// must write them only while the block is idle, which the block does not enforce.
module audio_peak_envelope_follower_top #(
    parameter int COEF_FRAC_BITS = apef_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [apef_pkg::SAMPLE_W-1:0] i_sample_0,
    input  logic signed [apef_pkg::SAMPLE_W-1:0] i_sample_1,
    input  logic signed [apef_pkg::SAMPLE_W-1:0] i_sample_2,
    input  logic signed [apef_pkg::SAMPLE_W-1:0] i_sample_3,
    input  logic signed [apef_pkg::SAMPLE_W-1:0] i_sample_4,
    input  logic signed [apef_pkg::SAMPLE_W-1:0] i_sample_5,
    input  logic signed [apef_pkg::SAMPLE_W-1:0] i_sample_6,
    input  logic signed [apef_pkg::SAMPLE_W-1:0] i_sample_7,
    input  logic                                 i_last_of_block,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [apef_pkg::MAG_W-1:0]           o_env_out_0,
    output logic [apef_pkg::MAG_W-1:0]           o_env_out_1,
    output logic [apef_pkg::MAG_W-1:0]           o_env_out_2,
    output logic [apef_pkg::MAG_W-1:0]           o_env_out_3,
    output logic [apef_pkg::MAG_W-1:0]           o_env_out_4,
    output logic [apef_pkg::MAG_W-1:0]           o_env_out_5,
    output logic [apef_pkg::MAG_W-1:0]           o_env_out_6,
    output logic [apef_pkg::MAG_W-1:0]           o_env_out_7,
    output logic [apef_pkg::MAG_W-1:0]           o_mix_env_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [3:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int NCH = apef_pkg::MAX_CHANNELS;
    localparam int MW  = apef_pkg::MAG_W;
    localparam int CW  = apef_pkg::COEF_W;
    localparam int CNW = apef_pkg::CNT_W;

    apef_pkg::t_state r_state, n_state;

    logic [CNW-1:0] r_channel_count;
    logic [CW-1:0]  r_decay_coef;
    logic [CW-1:0]  r_output_coef;
    logic           r_thumbnail_mode;

    logic signed [apef_pkg::SAMPLE_W-1:0] w_sample [NCH];
    logic signed [apef_pkg::SAMPLE_W-1:0] r_sample [NCH];
    logic                                 r_last;

    logic [CNW-1:0] w_cnt;
    logic [NCH-1:0] w_active;
    logic           w_accept;
    logic           w_slot_free;
    logic           w_cfg_wr;

    apef_pkg::t_lane_ctl  w_lane_base;
    apef_pkg::t_lane_ctl  w_chan_ctl [NCH];
    apef_pkg::t_merge_ctl w_merge_ctl;

    logic [MW-1:0] w_chan_mag [NCH];
    logic [MW-1:0] w_chan_result [NCH];
    logic [MW-1:0] w_mean_mag;
    logic [MW-1:0] w_mix_result;
    logic [CW-1:0] w_mix_env_coef;
    logic [CW-1:0] w_mix_sm_coef;

    logic          r_out_valid;
    logic [MW-1:0] r_env_out [NCH];
    logic [MW-1:0] r_mix_out;

    assign w_sample[0] = i_sample_0;
    assign w_sample[1] = i_sample_1;
    assign w_sample[2] = i_sample_2;
    assign w_sample[3] = i_sample_3;
    assign w_sample[4] = i_sample_4;
    assign w_sample[5] = i_sample_5;
    assign w_sample[6] = i_sample_6;
    assign w_sample[7] = i_sample_7;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // Configuration write and read
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count  <= apef_pkg::RST_CHANNEL_COUNT;
            r_decay_coef     <= apef_pkg::RST_DECAY_COEF;
            r_output_coef    <= apef_pkg::RST_OUTPUT_COEF;
            r_thumbnail_mode <= 1'b0;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                apef_pkg::REG_CHANNEL_COUNT:  r_channel_count  <= pwdata[CNW-1:0];
                apef_pkg::REG_DECAY_COEF:     r_decay_coef     <= pwdata[CW-1:0];
                apef_pkg::REG_OUTPUT_COEF:    r_output_coef    <= pwdata[CW-1:0];
                apef_pkg::REG_THUMBNAIL_MODE: r_thumbnail_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            apef_pkg::REG_CHANNEL_COUNT:  prdata = 32'(r_channel_count);
            apef_pkg::REG_DECAY_COEF:     prdata = 32'(r_decay_coef);
            apef_pkg::REG_OUTPUT_COEF:    prdata = 32'(r_output_coef);
            apef_pkg::REG_THUMBNAIL_MODE: prdata = 32'(r_thumbnail_mode);
            default:                      prdata = '0;
        endcase
    end

    // Clamp the channel count and build the active mask
    always_comb begin
        if (r_channel_count == '0) begin
            w_cnt = CNW'(1);
        end else if (r_channel_count > CNW'(NCH)) begin
            w_cnt = CNW'(NCH);
        end else begin
            w_cnt = r_channel_count;
        end
        for (int i = 0; i < NCH; i++) begin
            w_active[i] = (CNW'(i) < w_cnt);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            apef_pkg::ST_IDLE: if (i_in_valid) n_state = apef_pkg::ST_DIV;
            apef_pkg::ST_DIV:  n_state = apef_pkg::ST_PEAK;
            apef_pkg::ST_PEAK: n_state = apef_pkg::ST_EMUL;
            apef_pkg::ST_EMUL: n_state = apef_pkg::ST_EWB;
            apef_pkg::ST_EWB:  n_state = r_last ? apef_pkg::ST_SMUL : apef_pkg::ST_IDLE;
            apef_pkg::ST_SMUL: if (w_slot_free) n_state = apef_pkg::ST_SWB;
            apef_pkg::ST_SWB:  n_state = apef_pkg::ST_IDLE;
            default:           n_state = apef_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apef_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control outputs per state
    always_comb begin
        o_in_stall  = 1'b1;
        w_lane_base = '0;
        w_merge_ctl = '0;
        case (r_state)
            apef_pkg::ST_IDLE: begin
                o_in_stall       = 1'b0;
                w_merge_ctl.load = i_in_valid;
            end
            apef_pkg::ST_DIV: begin
                w_merge_ctl.mul = 1'b1;
            end
            apef_pkg::ST_PEAK: begin
                w_lane_base.peak_upd = 1'b1;
            end
            apef_pkg::ST_EMUL: begin
                w_lane_base.mul = 1'b1;
            end
            apef_pkg::ST_EWB: begin
                w_lane_base.wb = 1'b1;
            end
            apef_pkg::ST_SMUL: begin
                w_lane_base.mul     = 1'b1;
                w_lane_base.sm_step = 1'b1;
            end
            apef_pkg::ST_SWB: begin
                w_lane_base.wb      = 1'b1;
                w_lane_base.sm_step = 1'b1;
                w_lane_base.clr     = 1'b1;
            end
            default: ;
        endcase
    end

    // Gate the channel lanes: inactive lanes hold but for the peak clear, thumbnail mode freezes all
    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            w_chan_ctl[i].peak_upd = w_lane_base.peak_upd && w_active[i] && !r_thumbnail_mode;
            w_chan_ctl[i].mul      = w_lane_base.mul && w_active[i] && !r_thumbnail_mode;
            w_chan_ctl[i].wb       = w_lane_base.wb && w_active[i] && !r_thumbnail_mode;
            w_chan_ctl[i].sm_step  = w_lane_base.sm_step;
            w_chan_ctl[i].clr      = w_lane_base.clr && !r_thumbnail_mode;
            w_chan_mag[i]          = apef_pkg::mag15(r_sample[i]);
        end
    end

    // Hold the accepted frame
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= w_sample;
            r_last   <= i_last_of_block;
        end
    end

    apef_merge u_merge (
        .i_clk      (i_clk),
        .i_ctl      (w_merge_ctl),
        .i_sample   (w_sample),
        .i_active   (w_active),
        .i_cnt      (w_cnt),
        .o_mean_mag (w_mean_mag)
    );

    for (genvar g = 0; g < NCH; g++) begin : g_lane
        apef_lane #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_chan_ctl[g]),
            .i_mag      (w_chan_mag[g]),
            .i_env_coef (r_decay_coef),
            .i_sm_coef  (r_output_coef),
            .o_result   (w_chan_result[g])
        );
    end

    // A zero coefficient makes the pole copy its target: thumbnail passthrough
    assign w_mix_env_coef = r_thumbnail_mode ? '0 : r_decay_coef;
    assign w_mix_sm_coef  = r_thumbnail_mode ? '0 : r_output_coef;

    apef_lane #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mix_lane (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_lane_base),
        .i_mag      (w_mean_mag),
        .i_env_coef (w_mix_env_coef),
        .i_sm_coef  (w_mix_sm_coef),
        .o_result   (w_mix_result)
    );

    // Output register: load on the smoothing write, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == apef_pkg::ST_SWB) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == apef_pkg::ST_SWB) begin
            for (int i = 0; i < NCH; i++) begin
                r_env_out[i] <= (w_active[i] && !r_thumbnail_mode) ? w_chan_result[i] : '0;
            end
            r_mix_out <= w_mix_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_env_out_0   = r_env_out[0];
    assign o_env_out_1   = r_env_out[1];
    assign o_env_out_2   = r_env_out[2];
    assign o_env_out_3   = r_env_out[3];
    assign o_env_out_4   = r_env_out[4];
    assign o_env_out_5   = r_env_out[5];
    assign o_env_out_6   = r_env_out[6];
    assign o_env_out_7   = r_env_out[7];
    assign o_mix_env_out = r_mix_out;

    // A result appears only after a smoothing write
    a_out_from_swb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == apef_pkg::ST_SWB))
        else $error("result valid without smoothing write");

    // An accepted frame starts the divide step
    a_accept_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == apef_pkg::ST_DIV))
        else $error("accepted frame did not start processing");

    // A pending stalled result holds back the next smoothing write
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == apef_pkg::ST_SMUL && r_out_valid && i_out_stall)
        |=> (r_state == apef_pkg::ST_SMUL))
        else $error("result overwritten while stalled");

    // Thumbnail results carry no channel envelopes
    a_thumb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == apef_pkg::ST_SWB && r_thumbnail_mode)
        |=> (o_env_out_0 == '0 && o_env_out_1 == '0 && o_env_out_7 == '0))
        else $error("thumbnail result has channel envelopes");

endmodule

/* tb/audio_peak_envelope_follower_top_tb.sv */
`timescale 1ns / 1ps

module audio_peak_envelope_follower_top_tb;

    localparam int MAX_CHANNELS       = apef_pkg::MAX_CHANNELS;
    localparam int SAMPLE_W           = apef_pkg::SAMPLE_W;
    localparam int MAG_W              = apef_pkg::MAG_W;
    localparam int CNT_W              = apef_pkg::CNT_W;
    localparam int COEF_W             = apef_pkg::COEF_W;
    localparam int COEF_FRAC_BITS_DEF = apef_pkg::COEF_FRAC_BITS_DEF;
    localparam logic [MAG_W-1:0]  FULL_MAG          = apef_pkg::FULL_MAG;
    localparam logic [CNT_W-1:0]  RST_CHANNEL_COUNT = apef_pkg::RST_CHANNEL_COUNT;
    localparam logic [COEF_W-1:0] RST_DECAY_COEF    = apef_pkg::RST_DECAY_COEF;
    localparam logic [COEF_W-1:0] RST_OUTPUT_COEF   = apef_pkg::RST_OUTPUT_COEF;
    localparam logic [1:0] REG_CHANNEL_COUNT  = apef_pkg::REG_CHANNEL_COUNT;
    localparam logic [1:0] REG_DECAY_COEF     = apef_pkg::REG_DECAY_COEF;
    localparam logic [1:0] REG_OUTPUT_COEF    = apef_pkg::REG_OUTPUT_COEF;
    localparam logic [1:0] REG_THUMBNAIL_MODE = apef_pkg::REG_THUMBNAIL_MODE;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 4;
    localparam int SETTLE_WAIT  = 12;
    localparam int QUIET_LIMIT  = 2000;
    localparam int NUM_DIR      = 20;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 230;
    localparam int CALM_PHASE   = 3;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [0:MAX_CHANNELS-1][SAMPLE_W-1:0] smp;
        logic                                  last;
    } t_frame;

    typedef struct packed {
        logic [0:MAX_CHANNELS-1][MAG_W-1:0] env;
        logic [MAG_W-1:0]                   mix;
    } t_env_result;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [COEF_W-1:0] decay;
        logic [COEF_W-1:0] outc;
        logic              thumb;
    } t_setting;

    typedef struct packed {
        logic [2:0]  cfg;
        t_frame      frm;
        logic        typed;
        t_env_result want;
    } t_dir_row;

    // DUT signals
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [15:0] i_sample_0      = '0;
    logic [15:0] i_sample_1      = '0;
    logic [15:0] i_sample_2      = '0;
    logic [15:0] i_sample_3      = '0;
    logic [15:0] i_sample_4      = '0;
    logic [15:0] i_sample_5      = '0;
    logic [15:0] i_sample_6      = '0;
    logic [15:0] i_sample_7      = '0;
    logic        i_last_of_block = 1'b0;
    logic        i_out_stall     = 1'b0;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [3:0]  paddr           = '0;
    logic [31:0] pwdata          = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [MAG_W-1:0] o_env_out_0, o_env_out_1, o_env_out_2, o_env_out_3;
    logic [MAG_W-1:0] o_env_out_4, o_env_out_5, o_env_out_6, o_env_out_7;
    logic [MAG_W-1:0] o_mix_env_out;
    logic [31:0] prdata;
    logic        pready;

    // Follower state and register copy
    int                chan_env    [MAX_CHANNELS] = '{default: 0};
    int                chan_smooth [MAX_CHANNELS] = '{default: 0};
    int                chan_peak   [MAX_CHANNELS] = '{default: 0};
    int                mix_env     = 0;
    int                mix_smooth  = 0;
    int                mix_peak    = 0;
    logic [CNT_W-1:0]  cfg_count   = RST_CHANNEL_COUNT;
    logic [COEF_W-1:0] cfg_decay   = RST_DECAY_COEF;
    logic [COEF_W-1:0] cfg_outc    = RST_OUTPUT_COEF;
    logic              cfg_thumb   = 1'b0;

    t_env_result expected_envelopes [$];
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    bit          calm         = 1'b0;

    // Directed settings: reset values, then extremes and out-of-range values
    t_setting dir_set [5] = '{
        '{4'd2,  15'd13060, 15'd13060, 1'b0},
        '{4'd8,  15'd0,     15'd0,     1'b0},
        '{4'd3,  15'd16384, 15'd32767, 1'b1},
        '{4'd0,  15'd32767, 15'd16384, 1'b0},
        '{4'd15, 15'd16384, 15'd0,     1'b0}
    };

    // cfg, '{'{samples 0..7}, last}, typed, '{'{env_out 0..7}, mix_env_out}
    t_dir_row dir_tab [NUM_DIR] = '{
        // all zero after reset
        '{3'd0, '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1},
            1'b1, '0},
        // inactive channels carry content
        '{3'd0, '{'{16'sd32767, 16'h8000, 16'sd5, -16'sd5, 16'sd1000, -16'sd1000, 16'sd7,
            16'sd7}, 1'b0}, 1'b0, '0},
        '{3'd0, '{'{16'sd100, -16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
            1'b1}, 1'b0, '0},
        '{3'd0, '{'{-16'sd1, 16'sd1, 16'sd9, 16'sd9, 16'sd9, 16'sd9, 16'sd9, 16'sd9}, 1'b1},
            1'b0, '0},
        // zero coefficients: outputs are the block peaks
        '{3'd1, '{'{16'sd32767, 16'h8000, -16'sd1, 16'sd1, 16'sd0, 16'sd16384, -16'sd16384,
            16'sd12345}, 1'b1}, 1'b1,
            '{'{15'd32767, 15'd32767, 15'd1, 15'd1, 15'd0, 15'd16384, 15'd16384, 15'd12345},
            15'd1543}},
        // full-scale negative everywhere, mean saturates too
        '{3'd1, '{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
            16'h8000}, 1'b1}, 1'b1,
            '{'{15'd32767, 15'd32767, 15'd32767, 15'd32767, 15'd32767, 15'd32767, 15'd32767,
            15'd32767}, 15'd32767}},
        '{3'd1, '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
            16'sd32767, 16'sd32767}, 1'b0}, 1'b0, '0},
        // peak held from the previous frame of the block
        '{3'd1, '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1},
            1'b1,
            '{'{15'd32767, 15'd32767, 15'd32767, 15'd32767, 15'd32767, 15'd32767, 15'd32767,
            15'd32767}, 15'd32767}},
        // peaks cleared at block end
        '{3'd1, '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1},
            1'b1, '0},
        // mean truncates toward zero
        '{3'd1, '{'{-16'sd1, -16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1},
            1'b1, '{'{15'd1, 15'd1, 15'd1, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0}, 15'd0}},
        // thumbnail: mix peak only, unsmoothed
        '{3'd2, '{'{16'h8000, 16'h8000, 16'h8000, 16'sd1234, -16'sd4321, 16'sd77, 16'sd0,
            16'sd1}, 1'b0}, 1'b0, '0},
        '{3'd2, '{'{16'sd0, 16'sd0, 16'sd0, 16'sd500, 16'sd500, 16'sd500, 16'sd500, 16'sd500},
            1'b1}, 1'b1, '{'0, 15'd32767}},
        '{3'd2, '{'{16'sd300, -16'sd600, 16'sd0, 16'sd9999, 16'sd9999, 16'sd0, 16'sd0,
            16'sd0}, 1'b1}, 1'b1, '{'0, 15'd100}},
        // open block across the mode change
        '{3'd2, '{'{16'sd3000, 16'sd3000, 16'sd3000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
            1'b0}, 1'b0, '0},
        // count zero acts as one, coefficient above unity
        '{3'd3, '{'{-16'sd20000, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5},
            1'b1}, 1'b0, '0},
        '{3'd3, '{'{16'sd123, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
            1'b0}, 1'b0, '0},
        '{3'd3, '{'{16'h8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
            1'b1}, 1'b0, '0},
        // count above range acts as eight
        '{3'd4, '{'{16'sd1111, -16'sd2222, 16'sd3333, -16'sd4444, 16'sd5555, -16'sd6666,
            16'sd7777, -16'sd8888}, 1'b1}, 1'b0, '0},
        '{3'd4, '{'{-16'sd30000, 16'sd30000, 16'h8000, 16'sd32767, 16'sd1, -16'sd1, 16'sd2,
            -16'sd2}, 1'b0}, 1'b0, '0},
        '{3'd4, '{'{16'sd10, 16'sd20, 16'sd30, 16'sd40, 16'sd50, 16'sd60, 16'sd70, 16'sd80},
            1'b1}, 1'b0, '0}
    };

    audio_peak_envelope_follower_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sample_0      (i_sample_0),
        .i_sample_1      (i_sample_1),
        .i_sample_2      (i_sample_2),
        .i_sample_3      (i_sample_3),
        .i_sample_4      (i_sample_4),
        .i_sample_5      (i_sample_5),
        .i_sample_6      (i_sample_6),
        .i_sample_7      (i_sample_7),
        .i_last_of_block (i_last_of_block),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_env_out_0     (o_env_out_0),
        .o_env_out_1     (o_env_out_1),
        .o_env_out_2     (o_env_out_2),
        .o_env_out_3     (o_env_out_3),
        .o_env_out_4     (o_env_out_4),
        .o_env_out_5     (o_env_out_5),
        .o_env_out_6     (o_env_out_6),
        .o_env_out_7     (o_env_out_7),
        .o_mix_env_out   (o_mix_env_out),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Magnitude, full-scale negative clips to the largest positive value
    function automatic int sat_mag(input int x);
        int m;
        m = (x < 0) ? -x : x;
        return (m > int'(FULL_MAG)) ? int'(FULL_MAG) : m;
    endfunction

    // One-pole step toward target with floor rounding, clipped to 0..32767
    function automatic int pole_step(input int prev, input int target,
                                     input logic [COEF_W-1:0] coef);
        longint acc;
        acc = (longint'(prev) - longint'(target)) * longint'(coef);
        acc = (acc >>> COEF_FRAC_BITS_DEF) + longint'(target);
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > longint'(FULL_MAG)) begin
            acc = longint'(FULL_MAG);
        end
        return int'(acc);
    endfunction

    // Advance the follower by one frame; emit is set on a block end
    task automatic advance_follower(input t_frame f, output bit emit, output t_env_result r);
        int n;
        int sum;
        int m;
        int ch;
        n = int'(cfg_count);
        if (n < 1) begin
            n = 1;
        end
        if (n > MAX_CHANNELS) begin
            n = MAX_CHANNELS;
        end
        sum = 0;
        for (ch = 0; ch < n; ch++) begin
            sum += int'($signed(f.smp[ch]));
            if (!cfg_thumb) begin
                m = sat_mag(int'($signed(f.smp[ch])));
                if (chan_peak[ch] < m) begin
                    chan_peak[ch] = m;
                end
                chan_env[ch] = pole_step(chan_env[ch], chan_peak[ch], cfg_decay);
            end
        end
        m = sat_mag(sum / n);
        if (mix_peak < m) begin
            mix_peak = m;
        end
        mix_env = cfg_thumb ? mix_peak : pole_step(mix_env, mix_peak, cfg_decay);

        emit = f.last;
        r = '0;
        if (emit) begin
            if (cfg_thumb) begin
                mix_smooth = mix_env;
            end else begin
                for (ch = 0; ch < n; ch++) begin
                    chan_smooth[ch] = pole_step(chan_smooth[ch], chan_env[ch], cfg_outc);
                    r.env[ch] = MAG_W'(chan_smooth[ch]);
                end
                for (ch = 0; ch < MAX_CHANNELS; ch++) begin
                    chan_peak[ch] = 0;
                end
                mix_smooth = pole_step(mix_smooth, mix_env, cfg_outc);
            end
            r.mix = MAG_W'(mix_smooth);
            mix_peak = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [MAG_W-1:0] want_v,
                                   input logic [MAG_W-1:0] got_v);
        if (mismatches < MAX_REPORTS) begin
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want_v,
                     got_v);
        end
        mismatches++;
    endtask

    // Present one frame after a random gap and hold it until accepted
    task automatic send_frame(input t_frame f, input bit typed, input t_env_result want);
        int          gap;
        bit          emit;
        t_env_result calc;
        gap = (!calm && $urandom_range(99) < 35) ? int'($urandom_range(7, 1)) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_sample_0      <= f.smp[0];
        i_sample_1      <= f.smp[1];
        i_sample_2      <= f.smp[2];
        i_sample_3      <= f.smp[3];
        i_sample_4      <= f.smp[4];
        i_sample_5      <= f.smp[5];
        i_sample_6      <= f.smp[6];
        i_sample_7      <= f.smp[7];
        i_last_of_block <= f.last;
        do @(posedge i_clk); while (o_in_stall);
        advance_follower(f, emit, calc);
        if (emit) begin
            expected_envelopes.push_back(typed ? want : calc);
        end
    endtask

    // Drop valid, drain pending results and let the pipeline go idle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_envelopes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // APB write; psel stays high so back-to-back writes chain cleanly
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_CHANNEL_COUNT:  cfg_count = wdata[CNT_W-1:0];
            REG_DECAY_COEF:     cfg_decay = wdata[COEF_W-1:0];
            REG_OUTPUT_COEF:    cfg_outc  = wdata[COEF_W-1:0];
            REG_THUMBNAIL_MODE: cfg_thumb = wdata[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input t_setting s);
        write_reg(REG_CHANNEL_COUNT, 32'(s.count));
        write_reg(REG_DECAY_COEF, 32'(s.decay));
        write_reg(REG_OUTPUT_COEF, 32'(s.outc));
        write_reg(REG_THUMBNAIL_MODE, 32'(s.thumb));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(5))
            0:       return '0;
            1:       return COEF_W'(16384);
            2:       return '1;
            default: return COEF_W'($urandom_range(16384));
        endcase
    endfunction

    function automatic t_setting pick_setting();
        t_setting s;
        s.count = ($urandom_range(99) < 25) ? CNT_W'($urandom_range(15))
                                            : CNT_W'($urandom_range(8, 1));
        s.decay = pick_coef();
        s.outc  = pick_coef();
        s.thumb = ($urandom_range(99) < 25);
        return s;
    endfunction

    // Bias toward extremes and quiet signals, otherwise full range
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int k;
        k = int'($urandom_range(99));
        if (k < 4) begin
            return 16'h8000;
        end
        if (k < 8) begin
            return 16'h7FFF;
        end
        if (k < 10) begin
            return 16'hFFFF;
        end
        if (k < 40) begin
            return 16'($urandom_range(511) - 256);
        end
        return 16'($urandom);
    endfunction

    function automatic t_frame random_frame(input bit last);
        t_frame              f;
        logic [SAMPLE_W-1:0] shared;
        bit                  same;
        int                  ch;
        shared = rand_sample();
        same   = ($urandom_range(99) < 8);
        for (ch = 0; ch < MAX_CHANNELS; ch++) begin
            f.smp[ch] = same ? shared : rand_sample();
        end
        f.last = last;
        return f;
    endfunction

    // Random output stall, none during the calm phase
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 21);
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_env_result got;
        t_env_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.env = {o_env_out_0, o_env_out_1, o_env_out_2, o_env_out_3,
                       o_env_out_4, o_env_out_5, o_env_out_6, o_env_out_7};
            got.mix = o_mix_env_out;
            if (expected_envelopes.size() == 0) begin
                report_mismatch("unexpected result, mix_env_out", '0, got.mix);
            end else begin
                want = expected_envelopes.pop_front();
                for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
                    if (got.env[ch] !== want.env[ch]) begin
                        report_mismatch($sformatf("env_out_%0d", ch), want.env[ch],
                                        got.env[ch]);
                    end
                end
                if (got.mix !== want.mix) begin
                    report_mismatch("mix_env_out", want.mix, got.mix);
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int     cur_cfg;
        int     blk_left;
        int     ph;
        int     k;
        t_frame f;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, settings change only between drained phases
        cur_cfg = 0;
        for (k = 0; k < NUM_DIR; k++) begin
            if (int'(dir_tab[k].cfg) != cur_cfg) begin
                settle();
                cur_cfg = int'(dir_tab[k].cfg);
                apply_setting(dir_set[cur_cfg]);
            end
            send_frame(dir_tab[k].frm, dir_tab[k].typed, dir_tab[k].want);
        end

        // Random blocks; a block may stay open across a setting change
        blk_left = 0;
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            apply_setting(pick_setting());
            calm = (ph == CALM_PHASE);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (blk_left == 0) begin
                    blk_left = ($urandom_range(99) < 70) ? int'($urandom_range(6, 1))
                                                         : int'($urandom_range(24, 7));
                end
                f = random_frame(blk_left == 1);
                blk_left--;
                send_frame(f, 1'b0, '0);
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
